// ===== rtl/huffman_code_bit_packer_assert.svh =====
// Assertion macros used by the checker file of the code bit packer.
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in code bit packer");

// The consequent must hold in the cycle after the antecedent.
`define HCBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in code bit packer");

`endif

// ===== rtl/hcbp_pkg.sv =====
// Shared types and constants of the code bit packer.
`default_nettype none

package hcbp_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FLUSH  = 2'd2
    } func_t;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int STORE_BITS       = 32;
    localparam int BYTE_BITS        = 8;
    localparam int TABLE_DEPTH      = 256;
    localparam int MAX_RESULTS      = 4;

endpackage

`default_nettype wire

// ===== rtl/huffman_code_bit_packer.sv =====
// Top level of the code bit packer: code table memory, bit accumulator and byte output.
`default_nettype none

//  Channel   Handshake             Payload                                   Moves
//  input     in_valid / in_ready   func symbol code_value code_length        one command
//  output    out_valid / out_ready out_byte last_of_run                      one packed byte
//
//  A load transaction writes the code table in its accept cycle.
//  An encode transaction reads the table in its accept cycle and merges into the
//  accumulator once it holds less than a byte; the accumulator then drains one byte
//  per cycle while the output is not stalled, and an encode yields up to four bytes.
//  A flush with bits pending first pads them to a full byte, then emits it.
//  Reset clears the handshake state and the pending bit count; the table is not
//  cleared. A stalled output holds its byte and stops the drain, which in turn
//  fills the single command stage and drops in_ready.

module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  symbol,
    input  wire logic [31:0] code_value,
    input  wire logic [5:0]  code_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             last_of_run
);

    // Longest code that is ever stored; longer loads saturate to it.
    localparam int LEN_LIMIT = (MAX_CODE_LEN < hcbp_pkg::STORE_BITS) ?
                               MAX_CODE_LEN : hcbp_pkg::STORE_BITS;
    localparam int LEN_W     = $clog2(LEN_LIMIT + 1);
    localparam int ENT_W     = LEN_LIMIT + LEN_W;
    // The accumulator holds up to seven pending bits followed by one full code.
    localparam int ACC_W     = LEN_LIMIT + hcbp_pkg::BYTE_BITS - 1;
    localparam int CNT_W     = $clog2(ACC_W + 1);

    // Code table: the code bits sit above the length in each entry.
    logic [ENT_W-1:0] table_mem [hcbp_pkg::TABLE_DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    // Command stage that waits on the table read.
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_flush_reg;

    // Accumulator: the low cnt_reg bits of acc_reg are valid, oldest bit highest.
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    logic             in_fire;
    logic             load_fire;
    logic             enc_fire;
    logic             flush_fire;
    logic             s1_take;
    logic             cnt_ge_byte;
    logic             emit_fire;
    logic [5:0]       len_in_sat;
    logic [LEN_W-1:0] rd_len;
    logic [LEN_LIMIT-1:0] rd_code;
    logic [LEN_LIMIT-1:0] code_mask;
    logic [ACC_W-1:0] pend_bits;
    logic [CNT_W-1:0] remain_cnt;
    logic [ACC_W-1:0] emit_shift;

    // The command stage hands over only while the accumulator holds less than a byte,
    // so merging and draining never happen in the same cycle.
    assign cnt_ge_byte = (cnt_reg >= CNT_W'(hcbp_pkg::BYTE_BITS));
    assign s1_take     = s1_valid_reg && !cnt_ge_byte;
    assign in_ready    = !s1_valid_reg || s1_take;
    assign in_fire     = in_valid && in_ready;
    assign load_fire   = in_fire && (func == hcbp_pkg::FUNC_LOAD);
    assign enc_fire    = in_fire && (func == hcbp_pkg::FUNC_ENCODE);
    assign flush_fire  = in_fire && (func == hcbp_pkg::FUNC_FLUSH);

    // A byte leaves the accumulator whenever the output register is free or emptying.
    assign emit_fire   = cnt_ge_byte && (!out_valid_reg || out_ready);

    assign len_in_sat  = (code_length > 6'(LEN_LIMIT)) ? 6'(LEN_LIMIT) : code_length;

    // Loads write and encodes read in their accept cycles, in arrival order, so a
    // later encode always sees every earlier load without forwarding.
    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            table_mem[symbol] <= {code_value[LEN_LIMIT-1:0], LEN_W'(len_in_sat)};
        end
        if (enc_fire)
        begin
            rd_data_reg <= table_mem[symbol];
        end
    end

    assign rd_len    = rd_data_reg[LEN_W-1:0];
    assign rd_code   = rd_data_reg[ENT_W-1:LEN_W];
    assign code_mask = ~({LEN_LIMIT{1'b1}} << rd_len);
    assign pend_bits = acc_reg & ~({ACC_W{1'b1}} << cnt_reg);

    assign remain_cnt = cnt_reg - CNT_W'(hcbp_pkg::BYTE_BITS);
    assign emit_shift = acc_reg >> remain_cnt;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (enc_fire || flush_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_take)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (s1_take)
        begin
            if (s1_flush_reg)
            begin
                // Padding with zeros turns the pending bits into one full byte.
                if (cnt_reg != '0)
                begin
                    acc_next = pend_bits << (CNT_W'(hcbp_pkg::BYTE_BITS) - cnt_reg);
                    cnt_next = CNT_W'(hcbp_pkg::BYTE_BITS);
                end
            end
            else
            begin
                acc_next = (pend_bits << rd_len) | ACC_W'(rd_code & code_mask);
                cnt_next = cnt_reg + CNT_W'(rd_len);
            end
        end
        else if (emit_fire)
        begin
            cnt_next = remain_cnt;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (in_fire)
        begin
            s1_flush_reg <= (func == hcbp_pkg::FUNC_FLUSH);
        end
        if (emit_fire)
        begin
            out_byte_reg <= emit_shift[7:0];
            // The run ends when fewer than eight bits stay behind.
            out_last_reg <= (remain_cnt < CNT_W'(hcbp_pkg::BYTE_BITS));
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/hcbp_checker.sv =====
// Port-level checker of the code bit packer and its bind to the top level.
`default_nettype none

`include "huffman_code_bit_packer_assert.svh"

module hcbp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  out_byte,
    input wire logic        last_of_run
);

    logic [1:0] run_cnt_reg, run_cnt_next;
    logic       out_fire;

    assign out_fire = out_valid && out_ready;

    // Number of bytes already delivered in the current run.
    always_comb
    begin
        run_cnt_next = run_cnt_reg;
        if (out_fire)
        begin
            run_cnt_next = last_of_run ? 2'd0 : run_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg <= 2'd0;
        end
        else
        begin
            run_cnt_reg <= run_cnt_next;
        end
    end

    // A stalled byte stays offered and unchanged.
    `HCBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                      out_valid && $stable(out_byte) && $stable(last_of_run))

    // One command never yields more than four bytes.
    `HCBP_ASSERT_SAME(a_run_bound, out_fire && !last_of_run,
                      run_cnt_reg < 2'(hcbp_pkg::MAX_RESULTS - 1))

    // Back-pressure on the input only comes from pending bytes, so with the output
    // register empty a byte must appear in the next cycle.
    `HCBP_ASSERT_NEXT(a_stall_drains, !in_ready && !out_valid, out_valid)

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the code bit packer, with a built-in table and accumulator predictor.

module tb;

    // The command encoding leaves code 3 unused; the block must ignore it.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // The longest encode drains four bytes from the accumulator; the wait after the
    // last owed byte is enough for the block to go quiet.
    localparam int DRAIN_CYCLES   = 12;
    localparam int RUN_LIMIT_NS   = 400_000;
    localparam int CODE_LEN_LIMIT =
        (hcbp_pkg::MAX_CODE_LEN_DEF < hcbp_pkg::STORE_BITS) ? hcbp_pkg::MAX_CODE_LEN_DEF
                                                             : hcbp_pkg::STORE_BITS;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } packed_byte_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [1:0]  func        = hcbp_pkg::FUNC_LOAD;
    logic [7:0]  symbol      = 8'd0;
    logic [31:0] code_value  = 32'd0;
    logic [5:0]  code_length = 6'd0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [7:0]  out_byte;
    logic        last_of_run;

    // Idling on both channels is switched off for the final part of the run.
    bit idle_en = 1'b0;
    int ready_hold = 0;
    int error_count = 0;

    // Predictor state: the code table as loaded so far and the pending bits
    // that have not yet made up a whole byte.
    logic [31:0] code_table [hcbp_pkg::TABLE_DEPTH];
    logic [5:0]  len_table [hcbp_pkg::TABLE_DEPTH];
    bit          loaded [hcbp_pkg::TABLE_DEPTH];
    int          loaded_syms [$];
    logic [6:0]  acc_bits = 7'd0;
    logic [2:0]  acc_count = 3'd0;

    // Bytes still owed by the block, oldest first.
    packed_byte_t packed_byte_q [$];

    huffman_code_bit_packer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .symbol      (symbol),
        .code_value  (code_value),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Works out the bytes that one accepted command transaction must produce
    // and appends them to the queue of owed bytes.
    function automatic void predict_packed_bytes(input logic [1:0] f, input logic [7:0] sym,
                                                 input logic [31:0] val, input logic [5:0] len);
        logic [63:0]  acc;
        logic [15:0]  padded;
        int           n_len;
        int           total;
        packed_byte_t item;
        case (f)
            hcbp_pkg::FUNC_LOAD:
            begin
                // Lengths beyond what the table can hold saturate at load time.
                n_len = (int'(len) > CODE_LEN_LIMIT) ? CODE_LEN_LIMIT : int'(len);
                code_table[sym] = val;
                len_table[sym]  = 6'(n_len);
                if (!loaded[sym])
                begin
                    loaded[sym] = 1'b1;
                    loaded_syms.push_back(int'(sym));
                end
            end
            hcbp_pkg::FUNC_ENCODE:
            begin
                n_len = int'(len_table[sym]);
                if (n_len != 0)
                begin
                    // Only the low n_len bits of the stored code take part.
                    acc = ({57'd0, acc_bits} << n_len)
                        | ({32'd0, code_table[sym]} & ((64'd1 << n_len) - 64'd1));
                    total = int'(acc_count) + n_len;
                    while (total >= hcbp_pkg::BYTE_BITS)
                    begin
                        total -= hcbp_pkg::BYTE_BITS;
                        item.data = 8'(acc >> total);
                        item.last = (total < hcbp_pkg::BYTE_BITS);
                        packed_byte_q.push_back(item);
                    end
                    acc_count = 3'(total);
                    acc_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
                end
            end
            hcbp_pkg::FUNC_FLUSH:
            begin
                // A flush with nothing pending produces no byte at all.
                if (acc_count != 3'd0)
                begin
                    padded = {9'd0, acc_bits} << (hcbp_pkg::BYTE_BITS - int'(acc_count));
                    item.data = padded[7:0];
                    item.last = 1'b1;
                    packed_byte_q.push_back(item);
                    acc_bits  = 7'd0;
                    acc_count = 3'd0;
                end
            end
            default: ;
        endcase
    endfunction

    // Presents one command transaction at a falling edge, optionally after a
    // short idle burst, and holds it until the block takes it. The valid stays
    // high on return so that the next command can follow without a bubble.
    task automatic send_cmd(input logic [1:0] f, input logic [7:0] sym,
                            input logic [31:0] val, input logic [5:0] len);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        func        = f;
        symbol      = sym;
        code_value  = val;
        code_length = len;
        in_valid    = 1'b1;
        do @(posedge clk); while (!in_ready);
        predict_packed_bytes(f, sym, val, len);
    endtask

    // Stops sending, waits for every owed byte, then lets the block settle.
    task automatic wait_until_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (packed_byte_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The receiver stalls in random bursts while idling is enabled, and is always
    // ready otherwise.
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            out_ready = 1'b0;
        end
        else if (idle_en && $urandom_range(0, 4) == 0)
        begin
            ready_hold = $urandom_range(1, 6) - 1;
            out_ready  = 1'b0;
        end
        else
        begin
            out_ready = 1'b1;
        end
    end

    // Every byte transaction on the output is matched against the oldest
    // owed byte, field by field.
    always @(posedge clk)
    begin : check_packed_bytes
        packed_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (packed_byte_q.size() == 0)
            begin
                $error("unexpected output byte 0x%02h", out_byte);
                error_count++;
            end
            else
            begin
                want = packed_byte_q.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected 0x%02h, got 0x%02h", want.data, out_byte);
                    error_count++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
                    error_count++;
                end
            end
        end
    end

    // Hand-picked commands: extreme codes and lengths, saturation of long
    // lengths, a zero-length code, flushes with and without pending bits,
    // the unused command code, and an encode that yields four bytes.
    task automatic test_directed_cases();
        send_cmd(hcbp_pkg::FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
        send_cmd(hcbp_pkg::FUNC_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32);
        send_cmd(hcbp_pkg::FUNC_LOAD,   8'hFF, 32'h0000_0001, 6'd1);
        send_cmd(hcbp_pkg::FUNC_LOAD,   8'h80, 32'h5A5A_5A5A, 6'd0);
        send_cmd(hcbp_pkg::FUNC_LOAD,   8'h7F, 32'hDEAD_BEEF, 6'd63);
        send_cmd(hcbp_pkg::FUNC_LOAD,   8'h40, 32'h1234_5678, 6'd33);
        send_cmd(hcbp_pkg::FUNC_LOAD,   8'h01, 32'hFFFF_FFA5, 6'd8);
        send_cmd(hcbp_pkg::FUNC_LOAD,   8'h02, 32'h0000_0000, 6'd7);
        send_cmd(hcbp_pkg::FUNC_ENCODE, 8'hFF, 32'h0000_0000, 6'd0);
        send_cmd(hcbp_pkg::FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0);
        send_cmd(hcbp_pkg::FUNC_ENCODE, 8'h02, 32'hFFFF_FFFF, 6'h3F);
        send_cmd(hcbp_pkg::FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0);
        send_cmd(hcbp_pkg::FUNC_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send_cmd(hcbp_pkg::FUNC_ENCODE, 8'h80, 32'h0000_0000, 6'd0);
        // Seven pending bits followed by a full 32-bit code gives four bytes.
        send_cmd(hcbp_pkg::FUNC_ENCODE, 8'h02, 32'h0000_0000, 6'd0);
        send_cmd(hcbp_pkg::FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0);
        send_cmd(hcbp_pkg::FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
        send_cmd(hcbp_pkg::FUNC_ENCODE, 8'h7F, 32'h0000_0000, 6'd0);
        send_cmd(hcbp_pkg::FUNC_ENCODE, 8'h40, 32'h0000_0000, 6'd0);
        send_cmd(hcbp_pkg::FUNC_ENCODE, 8'h01, 32'h0000_0000, 6'd0);
        send_cmd(FUNC_UNUSED,           8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send_cmd(hcbp_pkg::FUNC_ENCODE, 8'hFF, 32'h0000_0000, 6'd0);
        send_cmd(hcbp_pkg::FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
        // Hold the sender until every owed byte has come back.
        wait_until_drained();
    endtask

    // Random traffic, mostly encodes of loaded symbols with short codes, plus
    // table reloads, flushes and ignored commands. Halfway through, the
    // sender pauses until the block has nothing left to deliver.
    task automatic test_random_traffic(input int n_items);
        int         pick;
        int         len_pick;
        logic [5:0] len;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (i == n_items / 2)
                wait_until_drained();
            if (loaded_syms.size() < 4 || pick < 15)
            begin
                len_pick = $urandom_range(0, 9);
                if (len_pick == 0)
                    len = 6'd0;
                else if (len_pick <= 6)
                    len = 6'($urandom_range(1, 12));
                else if (len_pick <= 8)
                    len = 6'($urandom_range(13, 32));
                else
                    len = 6'($urandom_range(33, 63));
                send_cmd(hcbp_pkg::FUNC_LOAD, 8'($urandom_range(0, 255)), $urandom(), len);
            end
            else if (pick < 80)
            begin
                // Only entries that have been written are ever looked up.
                send_cmd(hcbp_pkg::FUNC_ENCODE,
                         8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]),
                         $urandom(), 6'($urandom_range(0, 63)));
            end
            else if (pick < 95)
            begin
                send_cmd(hcbp_pkg::FUNC_FLUSH, 8'($urandom_range(0, 255)), $urandom(),
                         6'($urandom_range(0, 63)));
            end
            else
            begin
                send_cmd(FUNC_UNUSED, 8'($urandom_range(0, 255)), $urandom(),
                         6'($urandom_range(0, 63)));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idle_en = 1'b1;
        test_directed_cases();
        test_random_traffic(230);

        // The last stretch runs at full rate on both channels.
        idle_en = 1'b0;
        test_random_traffic(60);
        wait_until_drained();

        if (error_count == 0 && packed_byte_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop in case the block hangs on either channel.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
